// ===== rtl/htd_pkg.sv =====
// Shared types, codes and defaults for the Huffman table stream decoder.
`default_nettype none

package htd_pkg;

   localparam int DEF_MAX_CODE_LEN = 12;
   localparam int DEF_MAX_SYMBOLS  = 256;

   // Frame parsing phases.
   localparam logic [2:0] PH_HEAD     = 3'd0;
   localparam logic [2:0] PH_COUPLES  = 3'd1;
   localparam logic [2:0] PH_PATTERNS = 3'd2;
   localparam logic [2:0] PH_DATA     = 3'd3;
   localparam logic [2:0] PH_DONE     = 3'd4;

   // Error codes carried on a result.
   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_MAGIC     = 3'd1;
   localparam logic [2:0] ERR_COUPLES   = 3'd2;
   localparam logic [2:0] ERR_CODE_LEN  = 3'd3;
   localparam logic [2:0] ERR_BAD_CODE  = 3'd4;
   localparam logic [2:0] ERR_EMPTY     = 3'd5;

   localparam logic [7:0] MAGIC [4] = '{8'h48, 8'h45, 8'h33, 8'h0D};

   typedef struct packed {
      logic [7:0] in_byte;
      logic       frame_start;
   } htd_req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       is_last;
      logic       parity_ok;
      logic [2:0] error_code;
   } htd_rsp_type;

   typedef struct packed {
      logic take;
      logic clear_step;
      logic head_step;
      logic skip_step;
      logic skip_end;
      logic pat_bit;
      logic pat_end;
      logic dat_bit;
      logic dat_look;
   } htd_cmd_type;

   typedef struct packed {
      logic       out_free;
      logic [2:0] phase;
      logic       head_begin;
      logic       skip_more;
      logic       cidx_lt;
      logic       bits_done;
      logic       pat_store;
      logic       look_end;
      logic       clear_last;
      logic       dirty;
   } htd_sts_type;

endpackage

`default_nettype wire

// ===== rtl/huffman_table_stream_decoder_unit.sv =====
// Top level of the Huffman table stream decoder: controller plus datapath.
//
//  channel | direction | handshake           | payload
//  req     | in        | req_valid/req_ready | htd_req_type (in_byte, frame_start)
//  rsp     | out       | rsp_valid/rsp_ready | htd_rsp_type (out_byte, is_last,
//          |           |                     |   parity_ok, error_code)
//
// A header or couple byte goes through the dispatch step; the last couple byte adds a couple
// memory read, and one more for every zero-length couple that is skipped.
// A code block byte is stepped one bit at a time, with a couple memory read for every code it
// completes and an end-of-block step. A payload byte is stepped one bit at a time, each bit
// followed by a lookup in the registered code table read. After reset, and at a frame start
// when the previous frame stored codes, every code table entry is cleared with req_ready low.
// A result waiting on rsp_ready holds the decoder at its next header, couple, end-of-block
// or lookup step, whether or not that step produces a result.
`default_nettype none

module huffman_table_stream_decoder_unit
   import htd_pkg::*;
#(
   parameter int MAX_CODE_LEN = DEF_MAX_CODE_LEN,
   parameter int MAX_SYMBOLS  = DEF_MAX_SYMBOLS
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire htd_req_type req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output htd_rsp_type      rsp_data
);

   htd_cmd_type cmd;
   htd_sts_type sts;

   htd_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_frame_start (req_data.frame_start),
      .req_ready       (req_ready),
      .cmd             (cmd),
      .sts             (sts)
   );

   htd_datapath #(
      .MAX_CODE_LEN (MAX_CODE_LEN),
      .MAX_SYMBOLS  (MAX_SYMBOLS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ===== rtl/htd_ctrl.sv =====
// Sequencing state machine for the Huffman table stream decoder.
`default_nettype none

module htd_ctrl
   import htd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_frame_start,
   output logic             req_ready,
   output htd_cmd_type      cmd,
   input  wire htd_sts_type sts
);

   localparam logic [3:0] C_RCLR  = 4'd0;
   localparam logic [3:0] C_IDLE  = 4'd1;
   localparam logic [3:0] C_FCLR  = 4'd2;
   localparam logic [3:0] C_DISP  = 4'd3;
   localparam logic [3:0] C_FETCH = 4'd4;
   localparam logic [3:0] C_SKIP  = 4'd5;
   localparam logic [3:0] C_PBIT  = 4'd6;
   localparam logic [3:0] C_PEND  = 4'd7;
   localparam logic [3:0] C_DBIT  = 4'd8;
   localparam logic [3:0] C_DLOOK = 4'd9;

   logic [3:0] state_ff, state_in;
   logic       ctx_ff, ctx_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_RCLR;
         ctx_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         ctx_ff   <= ctx_in;
      end
   end

   assign req_ready = (state_ff == C_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      ctx_in   = ctx_ff;
      unique case (state_ff)
         C_RCLR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_last) state_in = C_IDLE;
         end
         C_IDLE: begin
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = (req_frame_start && sts.dirty) ? C_FCLR : C_DISP;
            end
         end
         C_FCLR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_last) state_in = C_DISP;
         end
         C_DISP: begin
            priority if (sts.phase == PH_PATTERNS) begin
               state_in = C_PBIT;
            end else if (sts.phase == PH_DATA) begin
               state_in = C_DBIT;
            end else if (sts.out_free) begin
               cmd.head_step = 1'b1;
               if (sts.head_begin) begin
                  ctx_in   = 1'b1;
                  state_in = C_FETCH;
               end else begin
                  state_in = C_IDLE;
               end
            end
         end
         // Wait state while the couple memories present the entry at the new index.
         C_FETCH: state_in = C_SKIP;
         C_SKIP: begin
            priority if (sts.skip_more) begin
               cmd.skip_step = 1'b1;
               state_in      = C_FETCH;
            end else if (!ctx_ff) begin
               state_in = C_PBIT;
            end else if (sts.out_free) begin
               cmd.skip_end = 1'b1;
               state_in     = C_IDLE;
            end
         end
         C_PBIT: begin
            if (sts.bits_done || !sts.cidx_lt) begin
               state_in = C_PEND;
            end else begin
               cmd.pat_bit = 1'b1;
               if (sts.pat_store) begin
                  ctx_in   = 1'b0;
                  state_in = C_FETCH;
               end
            end
         end
         C_PEND: begin
            if (sts.out_free) begin
               cmd.pat_end = 1'b1;
               state_in    = C_IDLE;
            end
         end
         C_DBIT: begin
            if (sts.bits_done) begin
               state_in = C_IDLE;
            end else begin
               cmd.dat_bit = 1'b1;
               state_in    = C_DLOOK;
            end
         end
         C_DLOOK: begin
            if (sts.out_free) begin
               cmd.dat_look = 1'b1;
               state_in     = sts.look_end ? C_IDLE : C_DBIT;
            end
         end
         default: state_in = C_IDLE;
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/htd_datapath.sv =====
// Frame registers, couple and code table memories and result register of the decoder.
`default_nettype none

module htd_datapath
   import htd_pkg::*;
#(
   parameter int MAX_CODE_LEN = DEF_MAX_CODE_LEN,
   parameter int MAX_SYMBOLS  = DEF_MAX_SYMBOLS
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire htd_req_type req_data,
   input  wire htd_cmd_type cmd,
   output htd_sts_type      sts,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output htd_rsp_type      rsp_data
);

   localparam int TAB_AW    = MAX_CODE_LEN + 1;
   localparam int TAB_DEPTH = 1 << TAB_AW;
   localparam int LEN_W     = $clog2(MAX_CODE_LEN + 1);
   localparam int SYM_AW    = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;

   logic [2:0]              phase_ff, phase_in;
   logic [3:0]              hdr_ff, hdr_in;
   logic [31:0]             exp_ff, exp_in;
   logic [31:0]             prod_ff, prod_in;
   logic [8:0]              ctot_ff, ctot_in;
   logic [8:0]              cidx_ff, cidx_in;
   logic [MAX_CODE_LEN-1:0] accum_ff, accum_in;
   logic [LEN_W-1:0]        taken_ff, taken_in;
   logic [7:0]              hpar_ff, hpar_in;
   logic [7:0]              rpar_ff, rpar_in;
   logic [7:0]              byte_ff, byte_in;
   logic [3:0]              bit_ff, bit_in;
   logic                    dirty_ff, dirty_in;
   logic [TAB_AW-1:0]       clr_ff, clr_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   htd_rsp_type             rsp_ff, rsp_in;

   logic [7:0]              sym_mem [MAX_SYMBOLS];
   logic [LEN_W-1:0]        len_mem [MAX_SYMBOLS];
   logic [8:0]              tab_mem [TAB_DEPTH];
   logic [7:0]              sym_rd_ff;
   logic [LEN_W-1:0]        len_rd_ff;
   logic [8:0]              tab_rd_ff;

   logic                    sym_we, len_we, tab_we;
   logic [TAB_AW-1:0]       tab_waddr, tab_raddr;
   logic [8:0]              tab_wdata;
   logic                    emit;
   htd_rsp_type             emit_data;
   logic                    bitv;
   logic [MAX_CODE_LEN:0]   shifted;
   logic [LEN_W:0]          taken_inc;
   logic [15:0]             count16;
   logic [31:0]             prod_inc;
   logic                    out_free;
   logic                    pat_store;

   function automatic logic [TAB_AW-1:0] tab_idx(input logic [LEN_W-1:0] t,
                                                 input logic [MAX_CODE_LEN-1:0] a);
      tab_idx = (TAB_AW'(1) << t) + TAB_AW'(a);
   endfunction

   assign bitv      = byte_ff[bit_ff[2:0]];
   assign shifted   = {accum_ff, bitv};
   assign taken_inc = (LEN_W + 1)'(taken_ff) + (LEN_W + 1)'(1);
   assign count16   = {byte_ff, ctot_ff[7:0]};
   assign prod_inc  = prod_ff + 32'd1;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign pat_store = (taken_inc >= (LEN_W + 1)'(len_rd_ff));

   always_comb begin
      sts            = '0;
      sts.out_free   = out_free;
      sts.phase      = phase_ff;
      sts.head_begin = (phase_ff == PH_COUPLES) && (hdr_ff != 4'd0) &&
                       (cidx_ff < 9'(MAX_SYMBOLS)) && (byte_ff <= 8'(MAX_CODE_LEN)) &&
                       ((cidx_ff + 9'd1) >= ctot_ff);
      sts.skip_more  = (cidx_ff < ctot_ff) && (len_rd_ff == '0);
      sts.cidx_lt    = (cidx_ff < ctot_ff);
      sts.bits_done  = bit_ff[3];
      sts.pat_store  = pat_store;
      sts.look_end   = tab_rd_ff[8] ? (prod_inc == exp_ff)
                                    : (taken_ff >= LEN_W'(MAX_CODE_LEN));
      sts.clear_last = &clr_ff;
      sts.dirty      = dirty_ff;
   end

   always_comb begin
      phase_in  = phase_ff;
      hdr_in    = hdr_ff;
      exp_in    = exp_ff;
      prod_in   = prod_ff;
      ctot_in   = ctot_ff;
      cidx_in   = cidx_ff;
      accum_in  = accum_ff;
      taken_in  = taken_ff;
      hpar_in   = hpar_ff;
      rpar_in   = rpar_ff;
      byte_in   = byte_ff;
      bit_in    = bit_ff;
      dirty_in  = dirty_ff;
      clr_in    = clr_ff;
      sym_we    = 1'b0;
      len_we    = 1'b0;
      tab_we    = 1'b0;
      tab_waddr = clr_ff;
      tab_wdata = '0;
      emit      = 1'b0;
      emit_data = '0;

      if (cmd.take) begin
         byte_in = req_data.in_byte;
         bit_in  = 4'd0;
         if (req_data.frame_start) begin
            phase_in = PH_HEAD;
            hdr_in   = 4'd0;
            exp_in   = '0;
            prod_in  = '0;
            ctot_in  = '0;
            cidx_in  = '0;
            accum_in = '0;
            taken_in = '0;
            hpar_in  = '0;
            rpar_in  = '0;
         end
      end

      if (cmd.clear_step) begin
         tab_we = 1'b1;
         clr_in = clr_ff + TAB_AW'(1);
         if (&clr_ff) dirty_in = 1'b0;
      end

      if (cmd.head_step) begin
         if (phase_ff == PH_HEAD) begin
            priority if (hdr_ff < 4'd4) begin
               if (byte_ff != MAGIC[hdr_ff[1:0]]) begin
                  emit                 = 1'b1;
                  emit_data.is_last    = 1'b1;
                  emit_data.error_code = ERR_MAGIC;
                  phase_in             = PH_DONE;
               end else begin
                  hdr_in = hdr_ff + 4'd1;
               end
            end else if (hdr_ff == 4'd4) begin
               hpar_in = byte_ff;
               hdr_in  = hdr_ff + 4'd1;
            end else if (hdr_ff <= 4'd8) begin
               unique case (hdr_ff[1:0])
                  2'd1: exp_in = exp_ff | {24'd0, byte_ff};
                  2'd2: exp_in = exp_ff | {16'd0, byte_ff, 8'd0};
                  2'd3: exp_in = exp_ff | {8'd0, byte_ff, 16'd0};
                  default: exp_in = exp_ff | {byte_ff, 24'd0};
               endcase
               hdr_in = hdr_ff + 4'd1;
            end else if (hdr_ff == 4'd9) begin
               ctot_in = {1'b0, byte_ff};
               hdr_in  = hdr_ff + 4'd1;
            end else begin
               hdr_in = 4'd0;
               if (count16 > 16'(MAX_SYMBOLS)) begin
                  emit                 = 1'b1;
                  emit_data.is_last    = 1'b1;
                  emit_data.error_code = ERR_COUPLES;
                  phase_in             = PH_DONE;
               end else begin
                  ctot_in  = count16[8:0];
                  cidx_in  = '0;
                  phase_in = PH_COUPLES;
                  // With no couples the code block is empty and decoding starts next, unless the count is zero.
                  if (count16 == 16'd0) begin
                     accum_in = '0;
                     taken_in = '0;
                     if (exp_ff == 32'd0) begin
                        emit                 = 1'b1;
                        emit_data.is_last    = 1'b1;
                        emit_data.error_code = ERR_EMPTY;
                        phase_in             = PH_DONE;
                     end else begin
                        phase_in = PH_DATA;
                     end
                  end
               end
            end
         end else if (phase_ff == PH_COUPLES) begin
            priority if (cidx_ff >= 9'(MAX_SYMBOLS)) begin
               emit                 = 1'b1;
               emit_data.is_last    = 1'b1;
               emit_data.error_code = ERR_COUPLES;
               phase_in             = PH_DONE;
            end else if (hdr_ff == 4'd0) begin
               sym_we = 1'b1;
               hdr_in = 4'd1;
            end else if (byte_ff > 8'(MAX_CODE_LEN)) begin
               emit                 = 1'b1;
               emit_data.is_last    = 1'b1;
               emit_data.error_code = ERR_CODE_LEN;
               phase_in             = PH_DONE;
            end else begin
               len_we  = 1'b1;
               hdr_in  = 4'd0;
               cidx_in = cidx_ff + 9'd1;
               if ((cidx_ff + 9'd1) >= ctot_ff) begin
                  cidx_in  = '0;
                  accum_in = '0;
                  taken_in = '0;
               end
            end
         end
      end

      if (cmd.skip_step) cidx_in = cidx_ff + 9'd1;

      if (cmd.skip_end || cmd.pat_end) begin
         if (cmd.skip_end && (cidx_ff < ctot_ff)) begin
            phase_in = PH_PATTERNS;
         end else if (cidx_ff >= ctot_ff) begin
            accum_in = '0;
            taken_in = '0;
            if (exp_ff == 32'd0) begin
               emit                 = 1'b1;
               emit_data.is_last    = 1'b1;
               emit_data.error_code = ERR_EMPTY;
               phase_in             = PH_DONE;
            end else begin
               phase_in = PH_DATA;
            end
         end
      end

      if (cmd.pat_bit) begin
         accum_in = shifted[MAX_CODE_LEN-1:0];
         taken_in = taken_inc[LEN_W-1:0];
         bit_in   = bit_ff + 4'd1;
         if (pat_store) begin
            tab_we    = 1'b1;
            tab_waddr = tab_idx(taken_inc[LEN_W-1:0], shifted[MAX_CODE_LEN-1:0]);
            tab_wdata = {1'b1, sym_rd_ff};
            cidx_in   = cidx_ff + 9'd1;
            accum_in  = '0;
            taken_in  = '0;
            dirty_in  = 1'b1;
         end
      end

      if (cmd.dat_bit) begin
         accum_in = shifted[MAX_CODE_LEN-1:0];
         taken_in = taken_inc[LEN_W-1:0];
         bit_in   = bit_ff + 4'd1;
      end

      if (cmd.dat_look) begin
         if (tab_rd_ff[8]) begin
            rpar_in            = rpar_ff ^ tab_rd_ff[7:0];
            prod_in            = prod_inc;
            accum_in           = '0;
            taken_in           = '0;
            emit               = 1'b1;
            emit_data.out_byte = tab_rd_ff[7:0];
            if (prod_inc == exp_ff) begin
               emit_data.is_last   = 1'b1;
               emit_data.parity_ok = ((rpar_ff ^ tab_rd_ff[7:0]) == hpar_ff);
               phase_in            = PH_DONE;
            end
         end else if (taken_ff >= LEN_W'(MAX_CODE_LEN)) begin
            emit                 = 1'b1;
            emit_data.is_last    = 1'b1;
            emit_data.error_code = ERR_BAD_CODE;
            phase_in             = PH_DONE;
         end
      end

      rsp_valid_in = emit ? 1'b1 : (rsp_valid_ff && !rsp_ready);
      rsp_in       = emit ? emit_data : rsp_ff;
   end

   // The lookup address follows the code being built, so the registered entry matches the code register.
   assign tab_raddr = tab_idx(taken_in, accum_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEAD;
         hdr_ff       <= '0;
         exp_ff       <= '0;
         prod_ff      <= '0;
         ctot_ff      <= '0;
         cidx_ff      <= '0;
         accum_ff     <= '0;
         taken_ff     <= '0;
         hpar_ff      <= '0;
         rpar_ff      <= '0;
         bit_ff       <= 4'd8;
         dirty_ff     <= 1'b1;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         hdr_ff       <= hdr_in;
         exp_ff       <= exp_in;
         prod_ff      <= prod_in;
         ctot_ff      <= ctot_in;
         cidx_ff      <= cidx_in;
         accum_ff     <= accum_in;
         taken_ff     <= taken_in;
         hpar_ff      <= hpar_in;
         rpar_ff      <= rpar_in;
         bit_ff       <= bit_in;
         dirty_ff     <= dirty_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      rsp_ff  <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (sym_we) sym_mem[cidx_ff[SYM_AW-1:0]] <= byte_ff;
      if (len_we) len_mem[cidx_ff[SYM_AW-1:0]] <= byte_ff[LEN_W-1:0];
      sym_rd_ff <= sym_mem[cidx_ff[SYM_AW-1:0]];
      len_rd_ff <= len_mem[cidx_ff[SYM_AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (tab_we) tab_mem[tab_waddr] <= tab_wdata;
      tab_rd_ff <= tab_mem[tab_raddr];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_emit_slot: assert property (@(posedge clock) disable iff (reset)
      emit |-> out_free)
      else $error("result produced while the output register was still occupied");

   a_error_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.error_code != ERR_NONE)) |->
         (rsp_ff.is_last && !rsp_ff.parity_ok && (rsp_ff.out_byte == 8'd0)))
      else $error("error result without the closing flag or with a symbol");

   a_store_phase: assert property (@(posedge clock) disable iff (reset)
      (cmd.pat_bit && pat_store) |-> (phase_ff == PH_PATTERNS))
      else $error("code table written outside the code block");

   a_code_len: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DATA) |-> (taken_ff <= LEN_W'(MAX_CODE_LEN)))
      else $error("payload code grew beyond the longest code");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the Huffman table stream decoder unit.
`default_nettype none

class htd_scoreboard;
   htd_pkg::htd_rsp_type pending[$];
   int unsigned          mismatches;
   int unsigned          results_seen;
   int unsigned          errors_seen;
   logic [2:0]           phase;
   int unsigned          head_idx;
   int unsigned          want_count;
   int unsigned          done_count;
   int unsigned          couple_cnt;
   int unsigned          couple_pos;
   logic [7:0]           sym_mem [256];
   logic [7:0]           len_mem [256];
   logic [8:0]           code_tab [8192];
   int unsigned          accum;
   int unsigned          taken;
   logic [7:0]           head_par;
   logic [7:0]           run_par;

   function new();
      mismatches   = 0;
      results_seen = 0;
      errors_seen  = 0;
      restart();
   endfunction

   function void restart();
      phase      = htd_pkg::PH_HEAD;
      head_idx   = 0;
      want_count = 0;
      done_count = 0;
      couple_cnt = 0;
      couple_pos = 0;
      accum      = 0;
      taken      = 0;
      head_par   = 0;
      run_par    = 0;
      foreach (code_tab[i]) code_tab[i] = '0;
   endfunction

   function void push(logic [7:0] sym, logic last, logic pok, logic [2:0] err);
      htd_pkg::htd_rsp_type r;
      r.out_byte   = sym;
      r.is_last    = last;
      r.parity_ok  = pok;
      r.error_code = err;
      pending.push_back(r);
   endfunction

   function void abort(logic [2:0] err);
      push(8'h00, 1'b1, 1'b0, err);
      phase = htd_pkg::PH_DONE;
   endfunction

   function void skip_unused();
      while (couple_pos < couple_cnt && couple_pos < 256 && len_mem[couple_pos] == 0)
         couple_pos++;
   endfunction

   function void start_payload();
      accum = 0;
      taken = 0;
      if (want_count == 0) abort(htd_pkg::ERR_EMPTY);
      else phase = htd_pkg::PH_DATA;
   endfunction

   function void start_codes();
      couple_pos = 0;
      accum      = 0;
      taken      = 0;
      skip_unused();
      if (couple_pos >= couple_cnt) start_payload();
      else phase = htd_pkg::PH_PATTERNS;
   endfunction

   // Work out the results caused by one accepted input transfer.
   function void note_input(htd_pkg::htd_req_type req);
      logic [7:0]  b;
      int unsigned total;
      int unsigned idx;
      b = req.in_byte;
      if (req.frame_start) restart();
      case (phase)
         htd_pkg::PH_HEAD: begin
            if (head_idx < 4) begin
               if (b != htd_pkg::MAGIC[head_idx]) abort(htd_pkg::ERR_MAGIC);
               else head_idx++;
            end else if (head_idx == 4) begin
               head_par = b;
               head_idx++;
            end else if (head_idx <= 8) begin
               want_count |= 32'(b) << (8 * (head_idx - 5));
               head_idx++;
            end else if (head_idx == 9) begin
               couple_cnt = b;
               head_idx++;
            end else begin
               total    = couple_cnt | (32'(b) << 8);
               head_idx = 0;
               if (total > 256) begin
                  abort(htd_pkg::ERR_COUPLES);
               end else begin
                  couple_cnt = total;
                  couple_pos = 0;
                  phase      = htd_pkg::PH_COUPLES;
                  if (couple_cnt == 0) start_codes();
               end
            end
         end
         htd_pkg::PH_COUPLES: begin
            if (couple_pos >= 256) begin
               abort(htd_pkg::ERR_COUPLES);
            end else if (head_idx == 0) begin
               sym_mem[couple_pos] = b;
               head_idx = 1;
            end else if (b > 12) begin
               abort(htd_pkg::ERR_CODE_LEN);
            end else begin
               len_mem[couple_pos] = b;
               couple_pos++;
               head_idx = 0;
               if (couple_pos >= couple_cnt) start_codes();
            end
         end
         htd_pkg::PH_PATTERNS: begin
            for (int i = 0; i < 8 && couple_pos < couple_cnt && couple_pos < 256; i++) begin
               accum = (accum << 1) | b[i];
               taken++;
               if (taken >= len_mem[couple_pos]) begin
                  idx = ((1 << taken) + accum) & 8191;
                  code_tab[idx] = {1'b1, sym_mem[couple_pos]};
                  couple_pos++;
                  accum = 0;
                  taken = 0;
                  skip_unused();
               end
            end
            if (couple_pos >= couple_cnt) start_payload();
         end
         htd_pkg::PH_DATA: begin
            for (int i = 0; i < 8 && phase == htd_pkg::PH_DATA; i++) begin
               accum = (accum << 1) | b[i];
               taken++;
               idx = ((1 << taken) + accum) & 8191;
               if (code_tab[idx][8]) begin
                  run_par ^= code_tab[idx][7:0];
                  done_count++;
                  accum = 0;
                  taken = 0;
                  if (done_count == want_count) begin
                     push(code_tab[idx][7:0], 1'b1, run_par == head_par, htd_pkg::ERR_NONE);
                     phase = htd_pkg::PH_DONE;
                  end else begin
                     push(code_tab[idx][7:0], 1'b0, 1'b0, htd_pkg::ERR_NONE);
                  end
               end else if (taken >= 12) begin
                  abort(htd_pkg::ERR_BAD_CODE);
               end
            end
         end
         default: ;
      endcase
   endfunction

   function void check_result(htd_pkg::htd_rsp_type got);
      htd_pkg::htd_rsp_type want;
      results_seen++;
      if (got.error_code != htd_pkg::ERR_NONE) errors_seen++;
      if (pending.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected result: byte %02h last %0b pok %0b err %0d",
                     got.out_byte, got.is_last, got.parity_ok, got.error_code);
         return;
      end
      want = pending.pop_front();
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch: exp byte %02h last %0b pok %0b err %0d, got byte %02h last %0b pok %0b err %0d",
                     want.out_byte, want.is_last, want.parity_ok, want.error_code,
                     got.out_byte, got.is_last, got.parity_ok, got.error_code);
      end
   endfunction
endclass

module tb;
   import htd_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ITEM_TARGET = 450;
   localparam int IDLE_LIMIT  = 50000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   htd_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   htd_rsp_type rsp_data;

   htd_scoreboard board = new();
   logic [7:0]    frame_q[$];
   bit            bit_q[$];
   int unsigned   sent_items = 0;
   int unsigned   frames_sent = 0;
   int unsigned   idle_cycles = 0;
   bit            no_gaps = 1'b0;
   bit            hold_done = 1'b0;

   huffman_table_stream_decoder_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic int pick_gap();
      if (no_gaps) return 0;
      return ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(10, 40);
   endfunction

   task automatic send_byte(logic [7:0] b, logic first);
      int gap;
      req_valid <= 1'b1;
      req_data  <= '{in_byte: b, frame_start: first};
      do @(posedge clock); while (!(req_valid && req_ready));
      sent_items++;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_frame(bit framed);
      foreach (frame_q[i]) send_byte(frame_q[i], framed && i == 0);
      frame_q.delete();
      frames_sent++;
   endtask

   // Code bits go into the stream first bit first, packed LSB-first into bytes.
   task automatic push_code(int unsigned val, int len);
      for (int i = len - 1; i >= 0; i--) bit_q.push_back(val[i]);
   endtask

   task automatic flush_bits();
      logic [7:0] b;
      while (bit_q.size() % 8 != 0) bit_q.push_back(1'($urandom));
      while (bit_q.size() > 0) begin
         for (int i = 0; i < 8; i++) b[i] = bit_q.pop_front();
         frame_q.push_back(b);
      end
   endtask

   task automatic put_header(logic [7:0] par, int unsigned count, int unsigned couples);
      foreach (MAGIC[i]) frame_q.push_back(MAGIC[i]);
      frame_q.push_back(par);
      for (int i = 0; i < 4; i++) frame_q.push_back(count[8*i +: 8]);
      frame_q.push_back(couples[7:0]);
      frame_q.push_back(couples[15:8]);
   endtask

   // A frame: nsym codes of length len (code i is value i), optional zero-length
   // couple, duplicate of code 0, parity error or bad code; count payload symbols.
   task automatic build_frame(int nsym, int len, int count, bit zero_len, bit dup,
                              bit good_par, bit bad_tail);
      logic [7:0]  syms [16];
      logic [7:0]  by_code [16];
      int unsigned codes [16];
      int          picks [16];
      int          zpos;
      int          total;
      int          hit;
      logic [7:0]  par;
      total = nsym + (zero_len ? 1 : 0);
      zpos  = $urandom_range(0, nsym);
      for (int i = 0; i < nsym; i++) begin
         syms[i]  = 8'($urandom);
         codes[i] = (dup && i == nsym - 1 && nsym > 1) ? 0 : i;
         by_code[codes[i]] = syms[i];
      end
      par = 0;
      for (int i = 0; i < count; i++) begin
         picks[i] = $urandom_range(0, (dup && nsym > 1) ? nsym - 2 : nsym - 1);
         par ^= by_code[picks[i]];
      end
      put_header(good_par ? par : 8'($urandom), count, total);
      for (int i = 0; i <= nsym; i++) begin
         if (zero_len && i == zpos) begin
            frame_q.push_back(8'($urandom));
            frame_q.push_back(8'd0);
         end
         if (i < nsym) begin
            frame_q.push_back(syms[i]);
            frame_q.push_back(8'(len));
         end
      end
      for (int i = 0; i < nsym; i++) push_code(codes[i], len);
      flush_bits();
      // The payload repeats the picks above, so a good parity byte really matches.
      hit = 0;
      for (int i = 0; i < count; i++) begin
         if (bad_tail && i == count / 2 && (1 << len) > nsym) begin
            push_code(nsym, len);
            for (int k = 0; k < 12; k++) bit_q.push_back(1'($urandom));
            hit = 1;
            break;
         end
         push_code(picks[i], len);
      end
      flush_bits();
      if (hit == 0 && $urandom_range(0, 3) == 0) frame_q.push_back(8'($urandom));
   endtask

   task automatic random_good_frame();
      int nsym;
      int len;
      nsym = $urandom_range(1, 12);
      len  = $clog2(nsym) < 1 ? 1 : $clog2(nsym);
      len  = len + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 12 - len) : 0);
      build_frame(nsym, len, $urandom_range(1, 14), $urandom_range(0, 4) == 0,
                  $urandom_range(0, 5) == 0, $urandom_range(0, 1), $urandom_range(0, 6) == 0);
   endtask

   task automatic directed_part();
      // Bytes right after reset already count as the start of a frame.
      build_frame(2, 1, 6, 0, 0, 1, 0);
      send_frame(1'b0);
      // Bytes after a finished frame are ignored.
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
      frame_q = '{8'h48, 8'h45, 8'h00};
      send_frame(1'b1);
      put_header(8'h00, 5, 257);
      send_frame(1'b1);
      put_header(8'h00, 5, 16'hFFFF);
      send_frame(1'b1);
      put_header(8'h00, 5, 1);
      frame_q.push_back(8'h41);
      frame_q.push_back(8'd13);
      send_frame(1'b1);
      put_header(8'h00, 0, 0);
      send_frame(1'b1);
      // No couples but a non-zero count: the payload can never match.
      put_header(8'h00, 3, 0);
      frame_q.push_back(8'hA5);
      frame_q.push_back(8'h5A);
      send_frame(1'b1);
      build_frame(3, 2, 0, 0, 0, 1, 0);
      send_frame(1'b1);
      build_frame(2, 12, 3, 1, 0, 1, 0);
      send_frame(1'b1);
      build_frame(4, 3, 8, 1, 1, 1, 1);
      send_frame(1'b1);
      build_frame(1, 1, 16, 0, 0, 0, 0);
      send_frame(1'b1);
   endtask

   task automatic random_part();
      int choice;
      int n;
      while (sent_items < ITEM_TARGET) begin
         no_gaps = ($urandom_range(0, 4) == 0);
         choice  = $urandom_range(0, 9);
         if (choice < 7) begin
            random_good_frame();
            send_frame(1'b1);
         end else if (choice < 9) begin
            // Broken frame: truncated or with one corrupted byte.
            random_good_frame();
            if ($urandom_range(0, 1)) frame_q = frame_q[0:$urandom_range(0, frame_q.size() - 1)];
            else frame_q[$urandom_range(0, frame_q.size() - 1)] = 8'($urandom);
            send_frame(1'b1);
         end else begin
            n = $urandom_range(1, 8);
            repeat (n) send_byte(8'($urandom), ($urandom_range(0, 5) == 0));
         end
      end
      no_gaps = 1'b0;
   endtask

   // Receiver: random stalls, plus one long hold-off so that the block backs up.
   initial begin
      int len;
      @(negedge reset);
      forever begin
         if (!hold_done && sent_items >= 150) begin
            rsp_ready <= 1'b0;
            repeat (600) @(posedge clock);
            hold_done = 1'b1;
         end
         rsp_ready <= 1'b1;
         len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
         repeat (len) @(posedge clock);
         len = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(10, 50);
         if (len > 0) begin
            rsp_ready <= 1'b0;
            repeat (len) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) board.note_input(req_data);
         if (rsp_valid && rsp_ready) board.check_result(rsp_data);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      directed_part();
      random_part();
      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("Sent %0d bytes in %0d frames or bursts; checked %0d results, %0d of them errors.",
               sent_items, frames_sent, board.results_seen, board.errors_seen);
      if (board.mismatches == 0 && board.pending.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d mismatches, %0d results still expected",
                  board.mismatches, board.pending.size());
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule

`default_nettype wire

// ===== sim.f =====
rtl/htd_pkg.sv
rtl/htd_ctrl.sv
rtl/htd_datapath.sv
rtl/huffman_table_stream_decoder_unit.sv
tb/tb.sv
